[rtl/dtp_pkg.sv]
// shared types, constants and field reader functions of the duration text parser
package dtp_pkg;

    localparam int FIELD_BUFFER_BYTES = 12;
    localparam int LEN_W = $clog2(FIELD_BUFFER_BYTES + 1);

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [1:0] AU_SKIP   = 2'd0;
    localparam logic [1:0] AU_DIGITS = 2'd1;
    localparam logic [1:0] AU_STOP   = 2'd2;

    localparam logic [1:0] MAX_COLONS = 2'd2;

    localparam logic [31:0] MAG_CAP = 32'h8000_0001;
    localparam logic [31:0] NEG_LIM = 32'h8000_0000;
    localparam logic [31:0] POS_LIM = 32'h7FFF_FFFF;

    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(FIELD_BUFFER_BYTES);

    typedef struct packed {
        logic [1:0]       mode;
        logic             neg;
        logic [31:0]      mag;
        logic [LEN_W-1:0] len;
    } au_t;

    typedef struct packed {
        au_t               seg;
        au_t               mic;
        logic [1:0]        colons;
        logic signed [31:0] cf0;
        logic signed [31:0] cf1;
        logic              dot;
        logic [LEN_W-1:0]  pre_len;
        logic              abort;
        logic              clamp;
    } rest_t;

    function automatic logic is_ws(logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic au_t au_feed(au_t u, logic [7:0] c);
        au_t r;
        logic digit;
        logic [35:0] prod;
        r = u;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        prod = {4'b0, u.mag} * 36'd10 + {32'b0, c[3:0]};
        if (u.len < LEN_CAP)
        begin
            r.len = u.len + 1'b1;
        end
        if (u.mode == AU_SKIP)
        begin
            if (!is_ws(c))
            begin
                if (c == CH_PLUS || c == CH_MINUS)
                begin
                    r.neg = (c == CH_MINUS);
                    r.mode = AU_DIGITS;
                end
                else if (digit)
                begin
                    r.mag = {28'b0, c[3:0]};
                    r.mode = AU_DIGITS;
                end
                else
                begin
                    r.mode = AU_STOP;
                end
            end
        end
        else if (u.mode == AU_DIGITS)
        begin
            if (digit)
            begin
                r.mag = (prod > {4'b0, MAG_CAP}) ? MAG_CAP : prod[31:0];
            end
            else
            begin
                r.mode = AU_STOP;
            end
        end
        return r;
    endfunction

    // closed form of n whitespace bytes into one reader
    function automatic au_t au_spaces(au_t u, logic [7:0] n);
        au_t r;
        logic [8:0] lsum;
        r = u;
        lsum = 9'(u.len) + {1'b0, n};
        r.len = (lsum >= 9'(FIELD_BUFFER_BYTES)) ? LEN_CAP : lsum[LEN_W-1:0];
        if (n != 8'd0 && u.mode == AU_DIGITS)
        begin
            r.mode = AU_STOP;
        end
        return r;
    endfunction

    // clamp flag on top, value below
    function automatic logic [32:0] au_value(au_t u);
        logic [32:0] r;
        if (u.neg)
        begin
            if (u.mag > NEG_LIM)
            begin
                r = {1'b1, NEG_LIM};
            end
            else
            begin
                r = {1'b0, 32'(-u.mag)};
            end
        end
        else
        begin
            if (u.mag > POS_LIM)
            begin
                r = {1'b1, POS_LIM};
            end
            else
            begin
                r = {1'b0, u.mag};
            end
        end
        return r;
    endfunction

    function automatic rest_t rest_chk(rest_t s, logic [LEN_W-1:0] len, logic cl);
        rest_t r;
        r = s;
        if (!s.abort)
        begin
            if (len >= LEN_CAP)
            begin
                r.abort = 1'b1;
            end
            else if (len != '0 && cl)
            begin
                r.clamp = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic rest_t rest_feed(rest_t s, logic [7:0] c);
        rest_t r;
        logic [32:0] v;
        r = s;
        v = au_value(s.seg);
        if (c == CH_COLON && s.colons < MAX_COLONS)
        begin
            r = rest_chk(s, s.seg.len, v[32]);
            if (s.colons[0] == 1'b0)
            begin
                r.cf0 = v[31:0];
            end
            else
            begin
                r.cf1 = v[31:0];
            end
            r.colons = s.colons + 1'b1;
            r.seg = '0;
            r.mic = '0;
            r.dot = 1'b0;
            r.pre_len = '0;
        end
        else if (!s.dot && c == CH_DOT)
        begin
            r.pre_len = s.seg.len;
            r.dot = 1'b1;
            r.seg = au_feed(s.seg, c);
        end
        else
        begin
            r.seg = au_feed(s.seg, c);
            if (s.dot)
            begin
                r.mic = au_feed(s.mic, c);
            end
        end
        return r;
    endfunction

    function automatic rest_t rest_spaces(rest_t s, logic [7:0] n);
        rest_t r;
        r = s;
        r.seg = au_spaces(s.seg, n);
        if (s.dot)
        begin
            r.mic = au_spaces(s.mic, n);
        end
        return r;
    endfunction

endpackage

[rtl/dtp_text_if.sv]
// byte channel of the duration text
interface dtp_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink (input valid, input char_code, input last_char, output ready);
endinterface

[rtl/dtp_span_if.sv]
// result channel of the duration total
interface dtp_span_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] span_micros;
    logic               field_too_long;
    logic               value_clamped;

    modport source (output valid, output span_micros, output field_too_long,
                    output value_clamped, input ready);
    modport sink (input valid, input span_micros, input field_too_long,
                  input value_clamped, output ready);
endinterface

[rtl/duration_text_parser_core.sv]
// duration text parser top level: byte parser and total pipeline
// one byte accepted per cycle while the result pipeline advances
// the last byte transfer edge loads the first of five stages; the result is valid once it reaches the fifth
// a full result register and a stalled sink hold the whole pipeline and the byte input
// reset clears the parser to the leading whitespace state and empties the pipeline
module duration_text_parser_core (
    input  logic clk,
    input  logic rst_n,
    dtp_text_if.sink   text,
    dtp_span_if.source span
);
    import dtp_pkg::*;

    localparam logic [2:0] PH_LEAD   = 3'd0;
    localparam logic [2:0] PH_FIRST  = 3'd1;
    localparam logic [2:0] PH_GAP    = 3'd2;
    localparam logic [2:0] PH_REST   = 3'd3;
    localparam logic [2:0] PH_NULLED = 3'd4;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  pend_reg, pend_next;
    au_t         day_reg, day_next;
    logic signed [31:0] dval_reg, dval_next;
    logic [1:0]  err_reg, err_next;
    rest_t       rest_reg, rest_next;

    logic        advance, take, sp;
    logic [32:0] dv, sv, mv;
    rest_t       rf, rs;
    logic        live, has_day, too_f, cl_f;
    logic signed [31:0] f_day, f_h, f_m, f_sec, f_mic;

    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [31:0] day1_reg, h1_reg, m1_reg, sec1_reg, mic1_reg;
    logic        too1_reg, too2_reg, too3_reg, too4_reg, too5_reg;
    logic        cl1_reg, cl2_reg, cl3_reg, cl4_reg, cl5_reg;
    logic signed [49:0] pd2_reg, ph2_reg, pm2_reg;
    logic signed [31:0] sec2_reg, mic2_reg, mic3_reg, mic4_reg;
    logic signed [49:0] s3_reg;
    logic [44:0] lo4_reg;
    logic signed [45:0] hi4_reg;
    logic signed [63:0] tot5_reg;
    logic signed [45:0] hi_ext;

    assign advance = !v5_reg || span.ready;
    assign text.ready = advance;
    assign take = text.valid && advance;
    assign sp = is_ws(text.char_code);

    always_comb
    begin
        phase_next = phase_reg;
        pend_next = pend_reg;
        day_next = day_reg;
        dval_next = dval_reg;
        err_next = err_reg;
        rest_next = rest_reg;
        dv = au_value(day_reg);
        rs = '0;
        unique case (phase_reg)
            PH_LEAD:
            begin
                if (!sp)
                begin
                    if (text.char_code == CH_NUL)
                    begin
                        phase_next = PH_NULLED;
                    end
                    else
                    begin
                        day_next = au_feed(day_reg, text.char_code);
                        rest_next = rest_feed(rest_reg, text.char_code);
                        phase_next = PH_FIRST;
                    end
                end
            end
            PH_FIRST:
            begin
                if (sp)
                begin
                    pend_next = 8'd1;
                    phase_next = PH_GAP;
                end
                else
                begin
                    day_next = au_feed(day_reg, text.char_code);
                    rest_next = rest_feed(rest_reg, text.char_code);
                end
            end
            PH_GAP:
            begin
                if (sp)
                begin
                    if (pend_reg != 8'hFF)
                    begin
                        pend_next = pend_reg + 8'd1;
                    end
                end
                else
                begin
                    dval_next = dv[31:0];
                    if (day_reg.len >= LEN_CAP)
                    begin
                        err_next = 2'b01;
                    end
                    else if (dv[32])
                    begin
                        err_next = 2'b10;
                    end
                    else
                    begin
                        err_next = 2'b00;
                    end
                    rs = rest_spaces('0, pend_reg - 8'd1);
                    rest_next = rest_feed(rs, text.char_code);
                    pend_next = 8'd0;
                    phase_next = PH_REST;
                end
            end
            PH_REST:
            begin
                if (sp)
                begin
                    if (pend_reg != 8'hFF)
                    begin
                        pend_next = pend_reg + 8'd1;
                    end
                end
                else
                begin
                    rs = rest_spaces(rest_reg, pend_reg);
                    rest_next = rest_feed(rs, text.char_code);
                    pend_next = 8'd0;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        // fields of the finished text
        live = (phase_next == PH_FIRST) || (phase_next == PH_GAP) || (phase_next == PH_REST);
        has_day = (phase_next == PH_REST);
        too_f = has_day && err_next[0];
        cl_f = has_day && err_next[1];
        rf = rest_next;
        sv = au_value(rf.seg);
        rf = rest_chk(rf, rf.dot ? rf.pre_len : rf.seg.len, sv[32]);
        mv = au_value(rf.mic);
        if (rf.dot)
        begin
            rf = rest_chk(rf, rf.mic.len, mv[32]);
        end
        if (!too_f)
        begin
            too_f = rf.abort;
            cl_f = cl_f || rf.clamp;
        end
        if (!live)
        begin
            too_f = 1'b0;
            cl_f = 1'b0;
        end
        f_day = '0;
        f_h = '0;
        f_m = '0;
        f_sec = '0;
        f_mic = '0;
        if (live && !too_f)
        begin
            f_day = has_day ? dval_next : 32'sd0;
            if (rf.colons == MAX_COLONS)
            begin
                f_h = rf.cf0;
                f_m = rf.cf1;
            end
            else if (rf.colons == 2'd1)
            begin
                f_m = rf.cf0;
            end
            f_sec = sv[31:0];
            f_mic = rf.dot ? mv[31:0] : 32'sd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            pend_reg <= '0;
            day_reg <= '0;
            dval_reg <= '0;
            err_reg <= '0;
            rest_reg <= '0;
        end
        else if (take)
        begin
            if (text.last_char)
            begin
                phase_reg <= PH_LEAD;
                pend_reg <= '0;
                day_reg <= '0;
                dval_reg <= '0;
                err_reg <= '0;
                rest_reg <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                pend_reg <= pend_next;
                day_reg <= day_next;
                dval_reg <= dval_next;
                err_reg <= err_next;
                rest_reg <= rest_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= take && text.last_char;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    assign hi_ext = {{21{s3_reg[49]}}, s3_reg[49:25]};

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            day1_reg <= f_day;
            h1_reg <= f_h;
            m1_reg <= f_m;
            sec1_reg <= f_sec;
            mic1_reg <= f_mic;
            too1_reg <= too_f;
            cl1_reg <= cl_f;

            pd2_reg <= {{18{day1_reg[31]}}, day1_reg} * 50'sd86400;
            ph2_reg <= {{18{h1_reg[31]}}, h1_reg} * 50'sd3600;
            pm2_reg <= {{18{m1_reg[31]}}, m1_reg} * 50'sd60;
            sec2_reg <= sec1_reg;
            mic2_reg <= mic1_reg;
            too2_reg <= too1_reg;
            cl2_reg <= cl1_reg;

            s3_reg <= pd2_reg + ph2_reg + pm2_reg + {{18{sec2_reg[31]}}, sec2_reg};
            mic3_reg <= mic2_reg;
            too3_reg <= too2_reg;
            cl3_reg <= cl2_reg;

            lo4_reg <= {20'b0, s3_reg[24:0]} * 45'd1000000;
            hi4_reg <= hi_ext * 46'sd1000000;
            mic4_reg <= mic3_reg;
            too4_reg <= too3_reg;
            cl4_reg <= cl3_reg;

            tot5_reg <= ({{18{hi4_reg[45]}}, hi4_reg} <<< 25) + {19'b0, lo4_reg}
                        + {{32{mic4_reg[31]}}, mic4_reg};
            too5_reg <= too4_reg;
            cl5_reg <= cl4_reg;
        end
    end

    assign span.valid = v5_reg;
    assign span.span_micros = tot5_reg;
    assign span.field_too_long = too5_reg;
    assign span.value_clamped = cl5_reg;

    a_too_long_zero: assert property (@(posedge clk) disable iff (!rst_n)
        span.valid && span.field_too_long |-> span.span_micros == 64'sd0)
        else $error("too long field with nonzero span");

    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        text.valid && text.ready && text.last_char |=> phase_reg == PH_LEAD)
        else $error("parser not back in leading state after last byte");

    a_pend_phase: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 8'd0 |-> (phase_reg == PH_GAP || phase_reg == PH_REST))
        else $error("pending whitespace outside gap or rest");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        text.valid && text.ready && text.last_char |=> v1_reg)
        else $error("last byte transfer without result in flight");

endmodule
